/* design/sem_pkg.sv */
// shared types and constants for the sobel edge magnitude block
package sem_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 12;
	localparam int CFG_DATA_W = 12;
	localparam int PIX_W      = 24;
	localparam int NUM_CH     = 3;

	localparam logic [15:0] SAT_LIMIT = 16'd65280;

	typedef enum logic [0:0] {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} sem_in_t;

	typedef struct packed {
		logic [7:0] edge_red;
		logic [7:0] edge_green;
		logic [7:0] edge_blue;
		logic       row_end;
		logic       frame_end;
	} sem_out_t;

	// channel 0 is red in the top byte
	function automatic logic [7:0] chan_byte(input logic [PIX_W-1:0] pix, input int ch);
		logic [7:0] b;
		case (ch)
			0:       b = pix[23:16];
			1:       b = pix[15:8];
			default: b = pix[7:0];
		endcase
		return b;
	endfunction

endpackage

/* design/sem_line_ram.sv */
// generic single-port-write, registered-read line memory
module sem_line_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/sem_sqrt.sv */
// three-lane digit-by-digit rounded integer square root, two radicand bits per cycle
module sem_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [2:0][15:0]        radicand,
	output logic                    done,
	output logic [2:0][7:0]         root
);

	import sem_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [2:0]       cnt_q;
	logic [2:0][15:0] val_q;
	logic [2:0][10:0] rem_q;
	logic [2:0][7:0]  root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [10:0] trial;
		logic [10:0] test;
		for (int c = 0; c < NUM_CH; c++) begin
			if (start) begin
				val_q[c]  <= radicand[c];
				rem_q[c]  <= '0;
				root_q[c] <= '0;
			end else if (busy_q) begin
				trial = {rem_q[c][8:0], val_q[c][15:14]};
				test  = {1'b0, root_q[c], 2'b01};
				val_q[c] <= {val_q[c][13:0], 2'b00};
				if (trial >= test) begin
					rem_q[c]  <= trial - test;
					root_q[c] <= {root_q[c][6:0], 1'b1};
				end else begin
					rem_q[c]  <= trial;
					root_q[c] <= {root_q[c][6:0], 1'b0};
				end
			end
		end
	end

	// round up when the remainder exceeds the root
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			root[c] = root_q[c] + 8'((rem_q[c] > {3'b000, root_q[c]}) ? 1 : 0);
		end
	end

	assign done = done_q;

endmodule

/* design/sobel_edge_magnitude.sv */
// top level: line memories, window, gradient datapath and control
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order, each channel filtered on its
// own with zero outside the frame. One item is worked on at a time. A pixel that yields no result
// passes only through accept and line memory read and window update. One that yields one passes
// through accept, line memory read and window update, gradient, squares, square-root load, 8
// square-root steps, done, output load. The square-root iteration is the longest part, and a
// result still held by out_stall keeps the block in output load. Results come one row and one
// pixel after their pixel; drain ticks (cmd = 1) after the last pixel flush the rest. A new item
// is taken while a result still waits on out_stall. No clearing pass is needed after reset.
module sobel_edge_magnitude (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  sem_pkg::sem_in_t                      in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output sem_pkg::sem_out_t                     out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]        cfg_data
);

	import sem_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_GRAD,
		ST_SQUARE,
		ST_START,
		ST_ROOT,
		ST_PUT
	} state_t;

	state_t               state_q;
	logic [WIDTH_W-1:0]   width_q;
	logic [HEIGHT_W-1:0]  height_q;
	logic [COL_W-1:0]     in_col_q;
	logic [HEIGHT_W-1:0]  in_row_q;
	logic [COL_W-1:0]     out_col_q;
	logic [ROW_W-1:0]     out_row_q;
	logic [8:0][PIX_W-1:0] taps_q;
	logic [PIX_W-1:0]     bot_q;
	logic                 data_q;
	logic [2:0][11:0]     gx_q;
	logic [2:0][11:0]     gy_q;
	logic [2:0][21:0]     sum_q;
	logic                 row_end_q;
	logic                 frame_end_q;
	logic                 out_valid_q;
	sem_out_t             out_q;

	logic [WIDTH_W-1:0]   w;
	logic [HEIGHT_W-1:0]  h;
	logic                 in_xfer;
	logic                 put_fire;
	logic                 near_we;
	logic [PIX_W-1:0]     near_rd;
	logic [PIX_W-1:0]     far_rd;
	logic [PIX_W-1:0]     mid;
	logic [PIX_W-1:0]     top;
	logic                 emit;
	logic                 left_m, right_m, top_m, bot_m;
	logic [2:0][11:0]     gx_c, gy_c;
	logic [2:0][15:0]     radicand;
	logic                 root_done;
	logic [2:0][7:0]      root;
	logic [2:0][7:0]      edge_c;

	// register values outside the legal range saturate
	always_comb begin
		if (width_q == '0) begin
			w = WIDTH_W'(1);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w = WIDTH_W'(MAX_WIDTH);
		end else begin
			w = width_q;
		end
		if (height_q == '0) begin
			h = HEIGHT_W'(1);
		end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
			h = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			h = height_q;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(MAX_WIDTH);
			height_q <= HEIGHT_W'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// result register free this cycle
	assign put_fire = (state_q == ST_PUT) && (!out_valid_q || !out_stall);

	// rows above the frame are masked instead of read
	assign mid = (data_q && in_row_q == '0) ? '0 : near_rd;
	assign top = (in_row_q >= HEIGHT_W'(2)) ? far_rd : '0;
	assign near_we = (state_q == ST_READ) && data_q;

	sem_line_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_near (
		.clk   (clk),
		.we    (near_we),
		.waddr (in_col_q),
		.wdata (bot_q),
		.re    (in_xfer),
		.raddr (in_col_q),
		.rdata (near_rd)
	);

	sem_line_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_far (
		.clk   (clk),
		.we    (near_we),
		.waddr (in_col_q),
		.wdata (mid),
		.re    (in_xfer),
		.raddr (in_col_q),
		.rdata (far_rd)
	);

	assign emit = (in_row_q >= HEIGHT_W'(2)) || (in_row_q == HEIGHT_W'(1) && in_col_q != '0);

	assign left_m  = (out_col_q == '0);
	assign right_m = ({1'b0, out_col_q} + WIDTH_W'(1)) >= w;
	assign top_m   = (out_row_q == '0);
	assign bot_m   = ({1'b0, out_row_q} + HEIGHT_W'(1)) >= h;

	always_comb begin
		logic [8:0][11:0] v;
		for (int c = 0; c < NUM_CH; c++) begin
			for (int k = 0; k < 9; k++) begin
				if ((k / 3 == 0 && top_m) || (k / 3 == 2 && bot_m) ||
				    (k % 3 == 0 && left_m) || (k % 3 == 2 && right_m)) begin
					v[k] = '0;
				end else begin
					v[k] = {4'b0000, chan_byte(taps_q[k], c)};
				end
			end
			gx_c[c] = (v[2] + {v[5][10:0], 1'b0} + v[8]) - (v[0] + {v[3][10:0], 1'b0} + v[6]);
			gy_c[c] = (v[6] + {v[7][10:0], 1'b0} + v[8]) - (v[0] + {v[1][10:0], 1'b0} + v[2]);
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			radicand[c] = sum_q[c][15:0];
			edge_c[c]   = (sum_q[c] > {6'b0, SAT_LIMIT}) ? 8'hFF : root[c];
		end
	end

	sem_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_START),
		.radicand (radicand),
		.done     (root_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			taps_q      <= '0;
			data_q      <= 1'b0;
			row_end_q   <= 1'b0;
			frame_end_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (put_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (in_row_q < h) begin
							if (in_data.cmd == CMD_PIXEL) begin
								data_q  <= 1'b1;
								state_q <= ST_READ;
							end
						end else begin
							data_q  <= 1'b0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					for (int k = 0; k < 3; k++) begin
						taps_q[k*3]   <= taps_q[k*3+1];
						taps_q[k*3+1] <= taps_q[k*3+2];
					end
					taps_q[2] <= top;
					taps_q[5] <= mid;
					taps_q[8] <= data_q ? bot_q : '0;
					if (({1'b0, in_col_q} + WIDTH_W'(1)) >= w) begin
						in_col_q <= '0;
						if (in_row_q <= HEIGHT_W'(MAX_HEIGHT)) begin
							in_row_q <= in_row_q + HEIGHT_W'(1);
						end
					end else begin
						in_col_q <= in_col_q + COL_W'(1);
					end
					state_q <= emit ? ST_GRAD : ST_IDLE;
				end
				ST_GRAD: begin
					row_end_q   <= right_m;
					frame_end_q <= right_m && bot_m;
					if (right_m && bot_m) begin
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end else if (right_m) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: state_q <= ST_START;
				ST_START:  state_q <= ST_ROOT;
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (put_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		logic signed [23:0] px, py;
		if (in_xfer) begin
			bot_q <= {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};
		end
		if (state_q == ST_GRAD) begin
			gx_q <= gx_c;
			gy_q <= gy_c;
		end
		if (state_q == ST_SQUARE) begin
			for (int c = 0; c < NUM_CH; c++) begin
				px = $signed(gx_q[c]) * $signed(gx_q[c]);
				py = $signed(gy_q[c]) * $signed(gy_q[c]);
				sum_q[c] <= {1'b0, px[20:0]} + {1'b0, py[20:0]};
			end
		end
		if (put_fire) begin
			out_q.edge_red   <= edge_c[0];
			out_q.edge_green <= edge_c[1];
			out_q.edge_blue  <= edge_c[2];
			out_q.row_end    <= row_end_q;
			out_q.frame_end  <= frame_end_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
